/* sv/deq_pkg.sv */
// shared types and constants of the double-ended queue
package deq_pkg;

  localparam int WORD_W   = 32;
  localparam int ACTION_W = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_QUERY      = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

/* sv/deq_if.sv */
// command and result channel interfaces of the double-ended queue
interface deq_cmd_if;
  import deq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [WORD_W-1:0]   push_word;

  modport source (output valid, output action, output push_word, input ready);
  modport sink   (input valid, input action, input push_word, output ready);
endinterface

interface deq_res_if #(
  parameter int CountWidth = 11
);
  import deq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [WORD_W-1:0]   popped_word;
  logic                       pop_valid;
  logic                       push_dropped;
  logic [CountWidth-1:0]      occupancy;
  logic                       is_empty;
  logic signed [WORD_W-1:0]   front_word;
  logic signed [WORD_W-1:0]   back_word;

  modport source (output valid, output popped_word, output pop_valid, output push_dropped,
                  output occupancy, output is_empty, output front_word, output back_word,
                  input ready);
  modport sink   (input valid, input popped_word, input pop_valid, input push_dropped,
                  input occupancy, input is_empty, input front_word, input back_word,
                  output ready);
endinterface

/* sv/double_ended_queue.sv */
// top level of the double-ended queue: pointers, count, end-word cache and result register
//
// A double-ended queue of signed 32-bit words held in a ring buffer of DEPTH entries.
// Each command item pushes at the front or back, pops from the front or back, or only
// queries (action codes five to seven also act as a query). Every command gives exactly
// one result item: the popped word with its valid flag, a flag for a push dropped on a
// full store, and the occupancy, empty flag, front word and back word after the action.
// The front and back words are kept in registers, so pushes, queries and pops that empty
// the queue need no memory read: the result is registered, and a new command is taken
// once the result register is free. A pop that leaves one or more words must refill
// the end word it removed from the memory, whose read port is registered, so such a pop
// goes through ST_FETCH, which also waits for a free result register. The word memory
// needs no clearing after reset: only entries inside the occupied region are ever read,
// and each of those was written by a push.
module double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  deq_cmd_if.sink   cmd,
  deq_res_if.source res
);
  import deq_pkg::*;

  localparam int AddrWidth  = $clog2(DEPTH);
  localparam int CountWidth = $clog2(DEPTH + 1);

  localparam logic [AddrWidth-1:0]  LastIdx  = AddrWidth'(DEPTH - 1);
  localparam logic [CountWidth-1:0] FullCnt  = CountWidth'(DEPTH);

  // ring pointers with wrap at the last entry
  function automatic logic [AddrWidth-1:0] ptr_inc(input logic [AddrWidth-1:0] p);
    ptr_inc = (p == LastIdx) ? '0 : p + AddrWidth'(1);
  endfunction

  function automatic logic [AddrWidth-1:0] ptr_dec(input logic [AddrWidth-1:0] p);
    ptr_dec = (p == '0) ? LastIdx : p - AddrWidth'(1);
  endfunction

  state_t state, state_next;

  // queue state: head points at the front word, tail at the back word
  logic [AddrWidth-1:0]  head, head_next;
  logic [AddrWidth-1:0]  tail, tail_next;
  logic [CountWidth-1:0] count, count_next;
  word_t                 front_cache, front_cache_next;
  word_t                 back_cache, back_cache_next;

  // pending refill while the memory read is in flight
  logic                  refill_front, refill_front_next;
  word_t                 pend_popped, pend_popped_next;

  // memory ports
  logic                  wr_en;
  logic [AddrWidth-1:0]  wr_addr;
  logic                  rd_en;
  logic [AddrWidth-1:0]  rd_addr;
  word_t                 rd_data;

  // result register
  logic                  out_valid;
  logic                  out_load;
  word_t                 out_popped;
  logic                  out_pop_valid;
  logic                  out_dropped;
  logic [CountWidth-1:0] out_count;
  word_t                 out_front;
  word_t                 out_back;

  logic    out_free;
  logic    accept;
  logic    empty;
  logic    full;
  action_t act;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == ST_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign empty     = (count == '0);
  assign full      = (count == FullCnt);
  assign act       = action_t'(cmd.action);

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    front_cache_next  = front_cache;
    back_cache_next   = back_cache;
    refill_front_next = refill_front;
    pend_popped_next  = pend_popped;
    wr_en             = 1'b0;
    wr_addr           = head;
    rd_en             = 1'b0;
    rd_addr           = head;
    out_load          = 1'b0;
    out_popped        = '0;
    out_pop_valid     = 1'b0;
    out_dropped       = 1'b0;
    out_count         = count;
    out_front         = front_cache;
    out_back          = back_cache;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PUSH_FRONT: begin
              if (full) begin
                out_dropped = 1'b1;
              end else begin
                head_next        = ptr_dec(head);
                wr_en            = 1'b1;
                wr_addr          = ptr_dec(head);
                count_next       = count + CountWidth'(1);
                front_cache_next = cmd.push_word;
                if (empty) begin
                  back_cache_next = cmd.push_word;
                end
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                out_dropped = 1'b1;
              end else begin
                tail_next       = ptr_inc(tail);
                wr_en           = 1'b1;
                wr_addr         = ptr_inc(tail);
                count_next      = count + CountWidth'(1);
                back_cache_next = cmd.push_word;
                if (empty) begin
                  front_cache_next = cmd.push_word;
                end
              end
            end
            ACT_POP_FRONT: begin
              if (!empty) begin
                out_popped    = front_cache;
                out_pop_valid = 1'b1;
                head_next     = ptr_inc(head);
                count_next    = count - CountWidth'(1);
                // new front comes from memory unless the queue drains
                if (count > CountWidth'(1)) begin
                  rd_en             = 1'b1;
                  rd_addr           = ptr_inc(head);
                  refill_front_next = 1'b1;
                end
              end
            end
            ACT_POP_BACK: begin
              if (!empty) begin
                out_popped    = back_cache;
                out_pop_valid = 1'b1;
                tail_next     = ptr_dec(tail);
                count_next    = count - CountWidth'(1);
                if (count > CountWidth'(1)) begin
                  rd_en             = 1'b1;
                  rd_addr           = ptr_dec(tail);
                  refill_front_next = 1'b0;
                end
              end
            end
            default: begin
              // query only: nothing changes
            end
          endcase

          out_count = count_next;
          out_front = front_cache_next;
          out_back  = back_cache_next;
          if (rd_en) begin
            pend_popped_next = out_popped;
            state_next       = ST_FETCH;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        // read data is ready; place it into the cache and release the result
        out_popped    = pend_popped;
        out_pop_valid = 1'b1;
        if (refill_front) begin
          out_front = rd_data;
        end else begin
          out_back = rd_data;
        end
        if (out_free) begin
          out_load         = 1'b1;
          front_cache_next = out_front;
          back_cache_next  = out_back;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= LastIdx;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    front_cache  <= front_cache_next;
    back_cache   <= back_cache_next;
    refill_front <= refill_front_next;
    pend_popped  <= pend_popped_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.popped_word  <= out_popped;
      res.pop_valid    <= out_pop_valid;
      res.push_dropped <= out_dropped;
      res.occupancy    <= out_count;
      res.is_empty     <= (out_count == '0);
      // end words read as zero on an empty queue
      res.front_word   <= (out_count == '0) ? '0 : out_front;
      res.back_word    <= (out_count == '0) ? '0 : out_back;
    end
  end

  assign res.valid = out_valid;

  deq_store #(
    .Depth     (DEPTH),
    .AddrWidth (AddrWidth)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.push_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // occupancy never runs past the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt)
    else $error("occupancy beyond store size");

  // one item cannot both pop a word and drop a push
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.pop_valid && res.push_dropped))
    else $error("pop and drop flagged together");

  // a front pop that leaves words behind waits for the refill read
  a_pop_refill: assert property (@(posedge clk) disable iff (rst)
    (accept && act == ACT_POP_FRONT && count > CountWidth'(1)) |=> state == ST_FETCH)
    else $error("front pop did not refill");

  // the counter grows by one on an accepted push to a store that is not full
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) && !full)
      |=> count == $past(count) + CountWidth'(1))
    else $error("push did not grow occupancy");

endmodule

/* sv/deq_store.sv */
// word memory of the ring buffer: one write port, one registered read port
module deq_store #(
  parameter int Depth = 1024,
  parameter int AddrWidth = 10
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [AddrWidth-1:0]            wr_addr,
  input  logic signed [deq_pkg::WORD_W-1:0] wr_data,
  input  logic                            rd_en,
  input  logic [AddrWidth-1:0]            rd_addr,
  output logic signed [deq_pkg::WORD_W-1:0] rd_data
);
  import deq_pkg::*;

  word_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
